FILE: hw/rtl/grayscale_erode_dilate_window_assert.svh
// Assertion macros used by the checker of the erode/dilate block.
`ifndef GRAYSCALE_ERODE_DILATE_WINDOW_ASSERT_SVH
`define GRAYSCALE_ERODE_DILATE_WINDOW_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ERD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ERD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/erd_pkg.sv
package erd_pkg;

    localparam int PIX_W     = 8;
    localparam int OUT_COL_W = 11;
    localparam int OUT_ROW_W = 16;
    localparam int ROW_W     = 17;
    localparam int HALF_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int WIDTH_W   = 12;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DILATE = 3'd4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // Maximum when dilating, minimum when eroding.
    function automatic logic [PIX_W-1:0] pix_ext(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b,
                                                 input logic dilate);
        if (dilate)
        begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: hw/rtl/erd_cell.sv
module erd_cell (
    input  logic                       clk,
    input  logic                       shift,
    input  logic                       dilate,
    input  logic [erd_pkg::PIX_W-1:0]  new_col,
    input  logic [erd_pkg::PIX_W-1:0]  nb_prefix,
    output logic [erd_pkg::PIX_W-1:0]  prefix
);
    import erd_pkg::*;

    logic [PIX_W-1:0] prefix_reg;
    logic [PIX_W-1:0] prefix_next;

    // Extreme over the newest column and everything the neighbor held.
    assign prefix_next = pix_ext(new_col, nb_prefix, dilate);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            prefix_reg <= prefix_next;
        end
    end

    assign prefix = prefix_reg;
endmodule

FILE: hw/rtl/grayscale_erode_dilate_window.sv
// Grayscale erosion / dilation over an odd rectangular window.
// Input stream s_*: one item per pixel in raster order; s_tuser is the opcode
// (0 pixel, 1 drain step for rows past the bottom edge), s_tdata the pixel.
// Output stream m_*: one item per output pixel, tlast on the last item caused
// by an input item, tuser on the bottom-right pixel of the frame.
// Config: cfg_we/cfg_index/cfg_data write a register at once and restart the
// frame; write only while idle.
// Each input item in an output row passes through: accept, setup, N row store
// reads for the column extreme (N up to 2*half_height+1, one memory port), a
// drain of the read pipe, one shift of the cell row, R results sent one a cycle
// from the output register while the receiver is ready, and a step to advance
// the position. Items in the first half_height rows of a frame skip the reads
// and results; drain items inside the frame end after setup.
// The horizontal window is a row of cells holding running column extremes.
// Reset clears positions and control; the row store is not cleared and is
// never read before it is written in the current frame.
// When the receiver stalls, the current result is held and the block waits.
module grayscale_erode_dilate_window #(
    parameter int MAX_WIDTH       = 2048,
    parameter int MAX_HALF_KERNEL = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [erd_pkg::PIX_W-1:0]      s_tdata,   // pixel_value
    input  logic                           s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_value[7:0], out_column[18:8], out_row[34:19], zero pad
    output logic [erd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,   // last_of_run
    output logic                           m_tuser,   // last_of_frame
    input  logic                           cfg_we,
    input  logic [erd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erd_pkg::CFG_W-1:0]      cfg_data
);
    import erd_pkg::*;

    localparam int RING  = 2 * MAX_HALF_KERNEL + 1;
    localparam int RW    = $clog2(RING);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = XW + 1;
    localparam int DEPTH = RING * (2 ** XW);

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_READ, S_SHIFT, S_EMIT, S_FIN} state_t;

    state_t state_reg;

    logic [WIDTH_W-1:0] cfg_w_reg;
    logic [15:0]        cfg_h_reg;
    logic [HALF_W-1:0]  cfg_hw_reg;
    logic [HALF_W-1:0]  cfg_hh_reg;
    logic               dilate_reg;

    logic [XW-1:0]  col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [RW-1:0]  ring_reg;

    logic [XW-1:0]    c_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             op_reg;
    logic             emit_reg;
    logic [XW-1:0]    last_reg;
    logic [XW-1:0]    xe_reg;
    logic [RW-1:0]    rd_ring_reg;
    logic [RW:0]      rd_left_reg;
    logic             rd_pend_reg;
    logic [PIX_W-1:0] mem_q_reg;
    logic [PIX_W-1:0] acc_reg;
    logic             shift_reg;

    logic [PIX_W-1:0] mem [DEPTH];

    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_valid_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    // Effective geometry.
    logic [WW-1:0]     w_eff;
    logic [15:0]       h_eff;
    logic [HALF_W-1:0] hw_eff;
    logic [HALF_W-1:0] hh_eff;
    logic [XW-1:0]     w_m1;
    logic [ROW_W-1:0]  h_m1;

    always_comb
    begin
        if (cfg_w_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(cfg_w_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(cfg_w_reg);
        end
        h_eff  = (cfg_h_reg == '0) ? 16'd1 : cfg_h_reg;
        hw_eff = (32'(cfg_hw_reg) > MAX_HALF_KERNEL) ? HALF_W'(MAX_HALF_KERNEL) : cfg_hw_reg;
        hh_eff = (32'(cfg_hh_reg) > MAX_HALF_KERNEL) ? HALF_W'(MAX_HALF_KERNEL) : cfg_hh_reg;
        w_m1   = XW'(w_eff - WW'(1));
        h_m1   = ROW_W'(h_eff) - ROW_W'(1);
    end

    // Setup values for the latched item.
    logic              in_frame;
    logic              skip;
    logic              c_last;
    logic              emit_c;
    logic [XW-1:0]     first_c;
    logic [XW-1:0]     last_c;
    logic [ROW_W-1:0]  o_row;
    logic [ROW_W-1:0]  lo_row;
    logic [ROW_W-1:0]  hi_row;
    logic [RW-1:0]     lo_ring;
    logic [RW:0]       ring_tmp;
    logic [ROW_W-1:0]  count_c;

    always_comb
    begin
        in_frame = row_reg < ROW_W'(h_eff);
        skip     = in_frame && (op_reg == OP_DRAIN);
        c_last   = (c_reg == w_m1);
        emit_c   = (row_reg >= ROW_W'(hh_eff)) && (c_last || (c_reg >= XW'(hw_eff)));
        if (c_last)
        begin
            first_c = (c_reg >= XW'(hw_eff)) ? c_reg - XW'(hw_eff) : '0;
            last_c  = c_reg;
        end
        else
        begin
            first_c = c_reg - XW'(hw_eff);
            last_c  = first_c;
        end
        o_row    = row_reg - ROW_W'(hh_eff);
        ring_tmp = (RW+1)'(ring_reg) + (RW+1)'(RING) - (RW+1)'({hh_eff, 1'b0});
        if (ring_tmp >= (RW+1)'(RING))
        begin
            ring_tmp = ring_tmp - (RW+1)'(RING);
        end
        if (o_row >= ROW_W'(hh_eff))
        begin
            lo_row  = o_row - ROW_W'(hh_eff);
            lo_ring = ring_tmp[RW-1:0];
        end
        else
        begin
            lo_row  = '0;
            lo_ring = '0;
        end
        hi_row  = in_frame ? row_reg : h_m1;
        count_c = hi_row - lo_row + ROW_W'(1);
    end

    // Chain of cells: cell k holds the extreme of the last k+1 columns.
    logic [PIX_W-1:0] prefix [RING];

    genvar gi;
    generate
        for (gi = 0; gi < RING; gi++)
        begin : g_cell
            logic [PIX_W-1:0] nb;
            if (gi == 0)
            begin : g_head
                assign nb = acc_reg;
            end
            else
            begin : g_body
                assign nb = prefix[gi-1];
            end
            erd_cell u_cell (
                .clk       (clk),
                .shift     (shift_reg),
                .dilate    (dilate_reg),
                .new_col   (acc_reg),
                .nb_prefix (nb),
                .prefix    (prefix[gi])
            );
        end
    endgenerate

    // Emit path: window spans columns xe-hw .. c, clipped at column zero.
    logic [XW:0]      span;
    logic [XW:0]      span_cl;
    logic [PIX_W-1:0] win_val;
    logic [ROW_W-1:0] out_o;
    logic             at_last;

    always_comb
    begin
        span    = (XW+1)'(c_reg - xe_reg) + (XW+1)'(hw_eff);
        span_cl = (span > (XW+1)'(c_reg)) ? (XW+1)'(c_reg) : span;
        win_val = prefix[span_cl[RW-1:0]];
        out_o   = row_reg - ROW_W'(hh_eff);
        at_last = (xe_reg == last_reg);
    end

    logic rd_issue;
    assign rd_issue = (state_reg == S_READ) && (rd_left_reg != '0);

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_PREP) && !skip && in_frame)
        begin
            mem[{ring_reg, c_reg}] <= pix_reg;
        end
        if (rd_issue)
        begin
            mem_q_reg <= mem[{rd_ring_reg, c_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cfg_w_reg   <= WIDTH_W'(640);
            cfg_h_reg   <= 16'd480;
            cfg_hw_reg  <= HALF_W'(1);
            cfg_hh_reg  <= HALF_W'(1);
            dilate_reg  <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            ring_reg    <= '0;
            rd_left_reg <= '0;
            rd_pend_reg <= 1'b0;
            shift_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            c_reg       <= '0;
            op_reg      <= OP_PIXEL;
            emit_reg    <= 1'b0;
        end
        else
        begin
            // advance the cell row once the column extreme is complete
            shift_reg   <= (state_reg == S_READ) && !rd_issue && !rd_pend_reg;
            rd_pend_reg <= rd_issue;
            if (m_valid_reg && m_tready && (state_reg != S_EMIT))
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDTH:  cfg_w_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_HEIGHT: cfg_h_reg  <= cfg_data;
                    REG_HALF_W: cfg_hw_reg <= cfg_data[HALF_W-1:0];
                    REG_HALF_H: cfg_hh_reg <= cfg_data[HALF_W-1:0];
                    REG_DILATE: dilate_reg <= cfg_data[0];
                    default: ;
                endcase
                if (cfg_index <= REG_DILATE)
                begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    ring_reg <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        c_reg     <= (WW'(col_reg) >= w_eff) ? '0 : col_reg;
                        pix_reg   <= s_tdata;
                        op_reg    <= s_tuser;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (skip)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        emit_reg    <= emit_c;
                        last_reg    <= last_c;
                        xe_reg      <= first_c;
                        rd_ring_reg <= lo_ring;
                        // every column of an output row feeds the cells
                        rd_left_reg <= (row_reg >= ROW_W'(hh_eff)) ? (RW+1)'(count_c) : '0;
                        acc_reg     <= dilate_reg ? PIX_MIN : PIX_MAX;
                        state_reg   <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (rd_issue)
                    begin
                        rd_left_reg <= rd_left_reg - (RW+1)'(1);
                        rd_ring_reg <= (rd_ring_reg == RW'(RING - 1)) ? '0
                                                                      : rd_ring_reg + RW'(1);
                    end
                    if (rd_pend_reg)
                    begin
                        acc_reg <= pix_ext(acc_reg, mem_q_reg, dilate_reg);
                    end
                    if (!rd_issue && !rd_pend_reg)
                    begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    state_reg <= emit_reg ? S_EMIT : S_FIN;
                end
                S_EMIT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {(OUT_DATA_W - PIX_W - OUT_COL_W - OUT_ROW_W)'(0),
                                        out_o[OUT_ROW_W-1:0],
                                        OUT_COL_W'(xe_reg), win_val};
                        m_last_reg  <= at_last;
                        m_user_reg  <= (out_o == h_m1) && (xe_reg == w_m1);
                        xe_reg      <= xe_reg + XW'(1);
                        if (at_last)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN:
                begin
                    if (c_reg == w_m1)
                    begin
                        col_reg <= '0;
                        if (row_reg >= h_m1 + ROW_W'(hh_eff))
                        begin
                            row_reg  <= '0;
                            ring_reg <= '0;
                        end
                        else
                        begin
                            row_reg  <= row_reg + ROW_W'(1);
                            ring_reg <= (ring_reg == RW'(RING - 1)) ? '0 : ring_reg + RW'(1);
                        end
                    end
                    else
                    begin
                        col_reg <= c_reg + XW'(1);
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;
endmodule

FILE: hw/rtl/erd_checker.sv
`include "grayscale_erode_dilate_window_assert.svh"

module erd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [erd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tuser
);
    import erd_pkg::*;

    `ERD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output item changed while stalled")
    `ERD_ASSERT_NOW(a_frame_ends_run, m_tvalid && m_tuser, m_tlast, "frame end not at end of run")
    `ERD_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
endmodule

bind grayscale_erode_dilate_window erd_checker u_erd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
